/* sv/rgfma_pkg.sv */
// Shared constants, types and helpers for the range glitch filter.
`default_nettype none

package rgfma_pkg;

  // Moving average store depth (entries)
  localparam int WINDOW_DEPTH = 24;

  // Distance field width
  localparam int DIST_W = 16;

  // Store index, sample count and sum widths
  localparam int IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = DIST_W + CNT_W;
  localparam int DIVC_W = $clog2(SUM_W + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GLITCH_STEP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THR_THRESHOLD = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GLITCH_LIMIT  = 3'd7;

  typedef logic [DIST_W-1:0] dist_t;

  // Magnitude of an 8-bit two's complement counter (-128 gives 128)
  function automatic logic [7:0] abs8(input logic [7:0] c);
    return c[7] ? (~c + 8'd1) : c;
  endfunction

endpackage

`default_nettype wire

/* sv/range_glitch_filter_moving_average.sv */
// Range glitch filter with optional moving average: top level.
//
// Usage: one range reading per item on the input channel (in_valid/in_stall),
// one filtered result per item on the output channel (out_valid/out_stall).
// An item is taken when valid is high and stall is low. Registers are written
// through cfg_valid/cfg_ready (cfg_ready is always high); the user must write
// them only while the block is idle, which the block itself does not enforce.
// The block handles one item at a time; in_stall is high from acceptance until
// the result is loaded into the output register. A waiting result does not
// block the next item from being accepted. With the glitch filter off, the
// decide step passes the held reading straight to the final step. With it on,
// each moving-average pass (n = effective window length, up to 24) runs one
// store write, n accumulate steps through the shared adder, a divide setup,
// a 21-step restoring divide on the same adder and one wrap-up. A pass whose
// sample is out of range or with averaging off skips the store write, the
// accumulation and the divide. An item runs one or two passes.
// When the receiver stalls, the result holds in the output register and
// the block stalls in its final step only if a second result is ready.
// Reset (rst, synchronous) restores register defaults, clears filter state
// and marks all average store entries empty.
`default_nettype none

module range_glitch_filter_moving_average (
  input  logic                                clk,
  input  logic                                rst,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rgfma_pkg::DIST_W-1:0]        raw_distance_cm,
  input  logic                                armed,
  input  logic [15:0]                         throttle_pwm,
  input  logic [31:0]                         now_ms,
  input  logic                                mark_unstable,
  // output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rgfma_pkg::DIST_W-1:0]        filtered_distance_cm,
  output logic [rgfma_pkg::DIST_W-1:0]        held_raw_cm,
  // configuration
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rgfma_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rgfma_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import rgfma_pkg::*;

  // Sequencer states
  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_DECIDE     = 3'd1;
  localparam logic [2:0] S_AVG_START  = 3'd2;
  localparam logic [2:0] S_AVG_ACC    = 3'd3;
  localparam logic [2:0] S_AVG_DIVSET = 3'd4;
  localparam logic [2:0] S_AVG_DIV    = 3'd5;
  localparam logic [2:0] S_AVG_END    = 3'd6;
  localparam logic [2:0] S_FINISH     = 3'd7;

  logic [2:0] state;

  // Configuration registers
  logic [1:0]  filter_mode;
  dist_t       glitch_step;
  dist_t       min_dist;
  dist_t       max_dist;
  logic [7:0]  window_len;
  logic [15:0] thr_threshold;
  logic [15:0] hold_time;
  logic [6:0]  glitch_limit;

  // Filter state
  dist_t       last_nonzero;
  dist_t       glitch_ref;
  logic [7:0]  glitch_cnt;
  logic        awaiting;
  logic [31:0] takeoff_time;
  logic [CNT_W-1:0] slot;
  logic        unstable_pending;
  dist_t       avg_store [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] store_valid;

  // Item registers
  dist_t       held;
  logic        armed_r;
  logic [15:0] thr_r;
  logic [31:0] now_r;

  // Average pass registers
  dist_t       avg_arg;
  dist_t       avg_res;
  logic        call_setref;
  logic        call2_pending;
  logic [SUM_W-1:0]  acc;
  logic [CNT_W-1:0]  cnt;
  logic [IDX_W-1:0]  idx;
  logic [CNT_W-1:0]  rem;
  logic [DIVC_W-1:0] div_left;

  // Output register
  dist_t       filt_out;
  dist_t       held_out;

  assign in_stall             = (state != S_IDLE);
  assign cfg_ready            = 1'b1;
  assign filtered_distance_cm = filt_out;
  assign held_raw_cm          = held_out;

  // Zero reading replaced by last nonzero
  dist_t held_val;
  assign held_val = (raw_distance_cm != '0) ? raw_distance_cm : last_nonzero;

  // Effective window and write slot
  logic [CNT_W-1:0] win_n;
  logic [CNT_W-1:0] slot_eff;
  logic [IDX_W-1:0] slot_idx;
  logic [WINDOW_DEPTH-1:0] wr_mask;
  logic in_range;
  logic avg_on;
  assign win_n = (window_len > 8'(WINDOW_DEPTH)) ? CNT_W'(WINDOW_DEPTH)
                                                 : window_len[CNT_W-1:0];
  assign slot_eff = ((win_n == '0) || (slot >= win_n)) ? '0 : slot;
  assign slot_idx = slot_eff[IDX_W-1:0];
  assign wr_mask  = {{(WINDOW_DEPTH-1){1'b0}}, 1'b1} << slot_idx;
  assign in_range = !((avg_arg > max_dist) || (avg_arg < min_dist));
  assign avg_on   = filter_mode[1] && in_range;

  // Store read for accumulation; empty entries read as zero
  dist_t rd_entry;
  logic  acc_last;
  assign rd_entry = store_valid[idx] ? avg_store[idx] : '0;
  assign acc_last = ((CNT_W'(idx) + CNT_W'(1)) == win_n);

  // Shared adder: accumulate, or trial subtract for the divider
  logic [CNT_W:0]   rem_shift;
  logic [SUM_W-1:0] alu_a;
  logic [SUM_W-1:0] alu_b;
  logic             alu_cin;
  logic [SUM_W:0]   alu_out;
  logic             div_ge;
  logic [CNT_W-1:0] rem_next;
  logic [SUM_W-1:0] quot_next;

  assign rem_shift = {rem, acc[SUM_W-1]};

  always_comb begin
    if (state == S_AVG_DIV) begin
      alu_a   = SUM_W'(rem_shift);
      alu_b   = ~SUM_W'(cnt);
      alu_cin = 1'b1;
    end else begin
      alu_a   = acc;
      alu_b   = SUM_W'(rd_entry);
      alu_cin = 1'b0;
    end
  end

  assign alu_out   = {1'b0, alu_a} + {1'b0, alu_b} + (SUM_W+1)'(alu_cin);
  assign div_ge    = alu_out[SUM_W];
  assign rem_next  = div_ge ? alu_out[CNT_W-1:0] : rem_shift[CNT_W-1:0];
  assign quot_next = {acc[SUM_W-2:0], div_ge};

  // Glitch decision terms
  logic [DIST_W:0] d_down;
  logic [DIST_W:0] d_up;
  logic            jump_down;
  logic            jump_up;
  logic            is_glitch;
  logic            take_now;
  logic            pre_takeoff;
  logic [31:0]     elapsed;
  logic            in_hold;
  logic [7:0]      cnt_step;
  logic [7:0]      step_mag;
  logic [7:0]      lim8;
  dist_t           clamped;

  assign d_down      = {1'b0, glitch_ref} - {1'b0, held};
  assign d_up        = {1'b0, held} - {1'b0, glitch_ref};
  assign jump_down   = $signed(d_down) >= $signed({1'b0, glitch_step});
  assign jump_up     = $signed(d_up) >= $signed({1'b0, glitch_step});
  assign is_glitch   = jump_down || jump_up;
  assign take_now    = awaiting && (thr_r > thr_threshold);
  assign pre_takeoff = !armed_r || (awaiting && !(thr_r > thr_threshold));
  assign elapsed     = now_r - takeoff_time;
  assign in_hold     = take_now || (elapsed <= {16'd0, hold_time});
  assign cnt_step    = jump_down ? (glitch_cnt + 8'd1) : (glitch_cnt - 8'd1);
  assign step_mag    = abs8(cnt_step);
  assign lim8        = {1'b0, glitch_limit};
  assign clamped     = (held > glitch_step) ? min_dist : held;

  // Average store data (no reset; validity kept in store_valid)
  always_ff @(posedge clk) begin
    if (state == S_AVG_START && avg_on) begin
      avg_store[slot_idx] <= avg_arg;
    end
  end

  // Sequencer, configuration and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      filter_mode      <= 2'd0;
      glitch_step      <= 16'd100;
      min_dist         <= 16'd20;
      max_dist         <= 16'd700;
      window_len       <= 8'd10;
      thr_threshold    <= 16'd1100;
      hold_time        <= 16'd0;
      glitch_limit     <= 7'd3;
      last_nonzero     <= '0;
      glitch_ref       <= '0;
      glitch_cnt       <= 8'd0;
      awaiting         <= 1'b0;
      takeoff_time     <= 32'd0;
      slot             <= '0;
      unstable_pending <= 1'b0;
      store_valid      <= '0;
      call_setref      <= 1'b0;
      call2_pending    <= 1'b0;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FILTER_MODE:   filter_mode   <= cfg_data[1:0];
          REG_GLITCH_STEP:   glitch_step   <= cfg_data;
          REG_MIN_DISTANCE:  min_dist      <= cfg_data;
          REG_MAX_DISTANCE:  max_dist      <= cfg_data;
          REG_WINDOW_LEN:    window_len    <= cfg_data[7:0];
          REG_THR_THRESHOLD: thr_threshold <= cfg_data;
          REG_HOLD_TIME:     hold_time     <= cfg_data;
          REG_GLITCH_LIMIT:  glitch_limit  <= cfg_data[6:0];
          default: ;
        endcase
      end

      // output register drains (the final step reloads it itself)
      if (out_valid && !out_stall && state != S_FINISH) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            last_nonzero <= held_val;
            held         <= held_val;
            armed_r      <= armed;
            thr_r        <= throttle_pwm;
            now_r        <= now_ms;
            if (mark_unstable) unstable_pending <= 1'b1;
            state <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          if (!filter_mode[0]) begin
            avg_res       <= held;
            call2_pending <= 1'b0;
            state         <= S_FINISH;
          end else begin
            state <= S_AVG_START;
            // arming and takeoff tracking
            if (!armed_r) begin
              awaiting <= 1'b1;
            end else if (take_now) begin
              takeoff_time <= now_r;
              awaiting     <= 1'b0;
            end
            if (pre_takeoff) begin
              avg_arg       <= clamped;
              call_setref   <= 1'b1;
              call2_pending <= 1'b0;
            end else if (in_hold) begin
              // uncounted replacement after takeoff
              call_setref   <= 1'b0;
              call2_pending <= 1'b0;
              if (is_glitch) begin
                avg_arg <= glitch_ref;
              end else begin
                glitch_ref <= held;
                avg_arg    <= held;
              end
            end else if (is_glitch) begin
              // counted replacement; limit reached accepts the new level
              glitch_cnt <= (step_mag >= lim8) ? 8'd0 : cnt_step;
              if (step_mag != lim8) begin
                avg_arg       <= glitch_ref;
                call_setref   <= 1'b0;
                call2_pending <= (step_mag >= lim8);
              end else begin
                avg_arg       <= held;
                call_setref   <= 1'b1;
                call2_pending <= 1'b0;
              end
            end else begin
              glitch_cnt    <= 8'd0;
              avg_arg       <= held;
              call_setref   <= 1'b1;
              call2_pending <= (lim8 == 8'd0);
            end
          end
        end

        S_AVG_START: begin
          if (!avg_on) begin
            avg_res <= avg_arg;
            state   <= S_AVG_END;
          end else begin
            store_valid      <= (unstable_pending ? '0 : store_valid) | wr_mask;
            unstable_pending <= 1'b0;
            slot             <= slot_eff;
            acc              <= '0;
            cnt              <= '0;
            idx              <= '0;
            state            <= (win_n == '0) ? S_AVG_DIVSET : S_AVG_ACC;
          end
        end

        S_AVG_ACC: begin
          if (rd_entry != '0) begin
            acc <= alu_out[SUM_W-1:0];
            cnt <= cnt + CNT_W'(1);
          end
          idx <= idx + IDX_W'(1);
          if (acc_last) state <= S_AVG_DIVSET;
        end

        S_AVG_DIVSET: begin
          if (cnt == '0) begin
            avg_res <= '0;
            state   <= S_AVG_END;
          end else begin
            slot     <= slot + CNT_W'(1);
            rem      <= '0;
            div_left <= DIVC_W'(SUM_W);
            state    <= S_AVG_DIV;
          end
        end

        S_AVG_DIV: begin
          acc      <= quot_next;
          rem      <= rem_next;
          div_left <= div_left - DIVC_W'(1);
          if (div_left == DIVC_W'(1)) begin
            avg_res <= quot_next[DIST_W-1:0];
            state   <= S_AVG_END;
          end
        end

        S_AVG_END: begin
          if (call_setref) glitch_ref <= avg_res;
          if (call2_pending) begin
            avg_arg       <= held;
            call_setref   <= 1'b1;
            call2_pending <= 1'b0;
            state         <= S_AVG_START;
          end else begin
            state <= S_FINISH;
          end
        end

        S_FINISH: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            filt_out  <= avg_res;
            held_out  <= held;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/rgfma_checker.sv */
// Port-level checks for the range glitch filter, bound to the top level.
`default_nettype none

module rgfma_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [rgfma_pkg::DIST_W-1:0]     filtered_distance_cm,
  input logic [rgfma_pkg::DIST_W-1:0]     held_raw_cm
);

  // Reset leaves the block idle with no pending result
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("block not idle after reset");

  // One item at a time: busy right after an item is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after item accepted");

  // A new result appears only as the block returns to idle
  a_result_ends_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_stall)
    else $error("result appeared while block still busy");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(filtered_distance_cm) && $stable(held_raw_cm)))
    else $error("stalled result changed");

endmodule

bind range_glitch_filter_moving_average rgfma_checker u_rgfma_checker (
  .clk                  (clk),
  .rst                  (rst),
  .in_valid             (in_valid),
  .in_stall             (in_stall),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .filtered_distance_cm (filtered_distance_cm),
  .held_raw_cm          (held_raw_cm)
);

`default_nettype wire

/* tb/range_glitch_filter_moving_average_tb.sv */
// Self-checking testbench for the range glitch filter with moving average.
`timescale 1ns / 100ps

module range_glitch_filter_moving_average_tb;
  import rgfma_pkg::*;

  typedef struct {
    dist_t       raw;
    logic        armed;
    logic [15:0] throttle;
    logic [31:0] now;
    logic        mark_unstable;
  } reading_t;

  typedef struct {
    dist_t filtered;
    dist_t held;
  } distance_pair_t;

  typedef struct {
    logic [1:0]  mode;
    dist_t       step;
    dist_t       min_d;
    dist_t       max_d;
    logic [7:0]  window;
    logic [15:0] throttle;
    logic [15:0] hold;
    logic [6:0]  limit;
  } filter_config_t;

  typedef enum {ON_GROUND, ARMED_IDLE, AIRBORNE} flight_stage_t;

  // Clock, reset and DUT ports
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  dist_t                 raw_distance_cm = '0;
  logic                  armed = 1'b0;
  logic [15:0]           throttle_pwm = '0;
  logic [31:0]           now_ms = '0;
  logic                  mark_unstable = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  dist_t                 filtered_distance_cm;
  dist_t                 held_raw_cm;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  range_glitch_filter_moving_average i_dut (
    .clk                  (clk),
    .rst                  (rst),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .raw_distance_cm      (raw_distance_cm),
    .armed                (armed),
    .throttle_pwm         (throttle_pwm),
    .now_ms               (now_ms),
    .mark_unstable        (mark_unstable),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .filtered_distance_cm (filtered_distance_cm),
    .held_raw_cm          (held_raw_cm),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  initial forever #10 clk = ~clk;

  // Queues and run control
  reading_t       readings_to_send[$];
  distance_pair_t expected_results[$];
  int             mismatch_count = 0;
  int             send_idle_pct = 10;
  int             recv_stall_pct = 84;
  int             hold_requests = 0;
  int             holds_served = 0;
  int             hold_left = 0;

  // Stimulus generator state
  logic [31:0]    clock_ms = '0;
  int             flight_level = 100;
  flight_stage_t  flight_stage = ON_GROUND;

  // Predictor copy of the registers (reset values)
  logic [1:0]  mode_r = 2'd0;
  dist_t       step_r = 16'd100;
  dist_t       min_r = 16'd20;
  dist_t       max_r = 16'd700;
  logic [7:0]  window_r = 8'd10;
  logic [15:0] throttle_r = 16'd1100;
  logic [15:0] hold_r = 16'd0;
  logic [6:0]  limit_r = 7'd3;

  // Predictor copy of the filter state (all zero after reset)
  dist_t       last_reading = '0;
  dist_t       ref_level = '0;
  logic [7:0]  jump_count = '0;
  logic        waiting_for_takeoff = 1'b0;
  logic [31:0] takeoff_ms = '0;
  dist_t       avg_window[WINDOW_DEPTH] = '{default: '0};
  int unsigned avg_slot = 0;
  logic        clear_pending = 1'b0;

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // Moving average over the in-range nonzero samples of the window
  function automatic dist_t window_average(input dist_t r);
    int unsigned n;
    int unsigned sum = 0;
    int unsigned cnt = 0;
    if (!mode_r[1]) return r;
    if (r > max_r || r < min_r) return r;
    if (clear_pending) begin
      foreach (avg_window[i]) avg_window[i] = '0;
      clear_pending = 1'b0;
    end
    n = (window_r > WINDOW_DEPTH) ? WINDOW_DEPTH : window_r;
    if (n == 0 || avg_slot >= n) avg_slot = 0;
    avg_window[avg_slot % WINDOW_DEPTH] = r;
    for (int i = 0; i < n; i++) begin
      if (avg_window[i] != 0) begin
        sum += avg_window[i];
        cnt++;
      end
    end
    if (cnt == 0) return '0;
    avg_slot = (avg_slot + 1) & 8'hFF;
    return dist_t'(sum / cnt);
  endfunction

  function automatic int jump_magnitude();
    int c;
    c = int'($signed(jump_count));
    return (c < 0) ? -c : c;
  endfunction

  // On the ground or before takeoff: big readings clamp to the minimum
  function automatic dist_t grounded_value(input dist_t r);
    dist_t v;
    v = (r > step_r) ? min_r : r;
    v = window_average(v);
    ref_level = v;
    return v;
  endfunction

  function automatic dist_t reject_jumps(input dist_t r, input logic arm,
                                         input logic [15:0] thr, input logic [31:0] now);
    int          g;
    int          x;
    int          step;
    int          lim;
    dist_t       v;
    logic [31:0] since;
    g = ref_level;
    x = r;
    step = step_r;
    lim = limit_r;
    if (!arm) begin
      waiting_for_takeoff = 1'b1;
      return grounded_value(r);
    end
    if (waiting_for_takeoff) begin
      if (thr > throttle_r) begin
        takeoff_ms = now;
        waiting_for_takeoff = 1'b0;
      end else begin
        return grounded_value(r);
      end
    end
    // hold window after takeoff: replace jumps, no counting
    since = now - takeoff_ms;
    if (since <= {16'd0, hold_r}) begin
      if (g - x >= step || x - g >= step) begin
        v = window_average(ref_level);
      end else begin
        ref_level = r;
        v = window_average(r);
      end
      return v;
    end
    // counted replacement until the new level persists
    if (g - x >= step || x - g >= step) begin
      if (g - x >= step) jump_count = jump_count + 8'd1;
      else jump_count = jump_count - 8'd1;
      v = ref_level;
      if (jump_magnitude() != lim) v = window_average(v);
    end else begin
      jump_count = '0;
      v = window_average(r);
      ref_level = v;
    end
    if (jump_magnitude() >= lim) begin
      jump_count = '0;
      v = window_average(r);
      ref_level = v;
    end
    return v;
  endfunction

  function automatic void predict_reading(input reading_t rd);
    distance_pair_t res;
    if (rd.mark_unstable) clear_pending = 1'b1;
    if (rd.raw != 0) last_reading = rd.raw;
    res.held = last_reading;
    res.filtered = last_reading;
    if (mode_r[0]) res.filtered = reject_jumps(last_reading, rd.armed, rd.throttle, rd.now);
    expected_results.push_back(res);
  endfunction

  function automatic int clip16(input int v);
    return (v < 0) ? 0 : (v > 65535) ? 65535 : v;
  endfunction

  function automatic filter_config_t build_config(
      input logic [1:0] mode, input dist_t step, input dist_t min_d, input dist_t max_d,
      input logic [7:0] window, input logic [15:0] thr, input logic [15:0] hold,
      input logic [6:0] limit);
    filter_config_t c;
    c.mode = mode;
    c.step = step;
    c.min_d = min_d;
    c.max_d = max_d;
    c.window = window;
    c.throttle = thr;
    c.hold = hold;
    c.limit = limit;
    return c;
  endfunction

  function automatic filter_config_t random_config();
    filter_config_t c;
    c.mode = ($urandom_range(0, 3) == 0) ? 2'($urandom) : 2'd3;
    case ($urandom_range(0, 4))
      0:       c.step = '0;
      1:       c.step = dist_t'($urandom);
      default: c.step = dist_t'($urandom_range(10, 300));
    endcase
    c.min_d = ($urandom_range(0, 3) == 0) ? '0 : dist_t'($urandom_range(1, 120));
    c.max_d = ($urandom_range(0, 5) == 0) ? 16'hFFFF : dist_t'($urandom_range(150, 1500));
    c.window = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 26));
    c.throttle = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(900, 1600));
    c.hold = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(0, 3000));
    c.limit = ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'($urandom_range(0, 6));
    return c;
  endfunction

  // One register write; valid stays high for a following write
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FILTER_MODE:   mode_r = data[1:0];
      REG_GLITCH_STEP:   step_r = data;
      REG_MIN_DISTANCE:  min_r = data;
      REG_MAX_DISTANCE:  max_r = data;
      REG_WINDOW_LEN:    window_r = data[7:0];
      REG_THR_THRESHOLD: throttle_r = data;
      REG_HOLD_TIME:     hold_r = data;
      REG_GLITCH_LIMIT:  limit_r = data[6:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input filter_config_t c);
    @(posedge clk);
    write_register(REG_FILTER_MODE, 16'(c.mode));
    write_register(REG_GLITCH_STEP, c.step);
    write_register(REG_MIN_DISTANCE, c.min_d);
    write_register(REG_MAX_DISTANCE, c.max_d);
    write_register(REG_WINDOW_LEN, 16'(c.window));
    write_register(REG_THR_THRESHOLD, c.throttle);
    write_register(REG_HOLD_TIME, c.hold);
    write_register(REG_GLITCH_LIMIT, 16'(c.limit));
    cfg_valid <= 1'b0;
  endtask

  // Sender pauses here until every item is out and every result is back
  task automatic wait_drained();
    do @(negedge clk); while (readings_to_send.size() != 0 || expected_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic push_reading(input dist_t raw, input logic arm, input logic [15:0] thr,
                              input logic [31:0] now, input logic mark);
    reading_t rd;
    rd.raw = raw;
    rd.armed = arm;
    rd.throttle = thr;
    rd.now = now;
    rd.mark_unstable = mark;
    readings_to_send.push_back(rd);
  endtask

  // Flight profiles: ground, armed idle, takeoff, flight with spikes and
  // level changes; a slice of fully random readings as noise
  task automatic queue_flight(input int count);
    reading_t rd;
    int       lo;
    int       hi;
    int       jump;
    int       span;
    int       thr_hi;
    lo = min_r;
    hi = (max_r > min_r) ? int'(max_r) : lo + 500;
    flight_level = clip16(int'($urandom_range(lo, clip16(hi))));
    repeat (count) begin
      if ($urandom_range(0, 99) < 8) begin
        rd.raw = dist_t'($urandom);
        rd.armed = 1'($urandom);
        rd.throttle = 16'($urandom);
        rd.now = $urandom;
        rd.mark_unstable = 1'($urandom);
      end else begin
        case (flight_stage)
          ON_GROUND:  if ($urandom_range(0, 14) == 0) flight_stage = ARMED_IDLE;
          ARMED_IDLE: begin
            if ($urandom_range(0, 3) == 0) flight_stage = AIRBORNE;
            else if ($urandom_range(0, 19) == 0) flight_stage = ON_GROUND;
          end
          default:    if ($urandom_range(0, 59) == 0) flight_stage = ON_GROUND;
        endcase
        rd.armed = (flight_stage != ON_GROUND);
        if (flight_stage == AIRBORNE) begin
          thr_hi = clip16(int'(throttle_r) + 600);
          rd.throttle = (throttle_r == 16'hFFFF) ? 16'hFFFF
                        : 16'($urandom_range(int'(throttle_r) + 1, thr_hi));
        end else begin
          rd.throttle = 16'($urandom_range(0, int'(throttle_r)));
        end
        if ($urandom_range(0, 7) == 0)
          clock_ms = clock_ms + $urandom_range(0, 2 * int'(hold_r) + 200);
        else
          clock_ms = clock_ms + $urandom_range(1, 50);
        rd.now = clock_ms;
        jump = int'(step_r) + int'($urandom_range(1, 300));
        span = int'(step_r) / 2;
        if (span > 200) span = 200;
        case ($urandom_range(0, 19))
          0:       rd.raw = '0;
          1, 2:    rd.raw = dist_t'(clip16(flight_level + jump));
          3:       rd.raw = dist_t'(clip16(flight_level - jump));
          4: begin
            flight_level = clip16(flight_level + (($urandom_range(0, 1) == 1) ? jump : -jump));
            rd.raw = dist_t'(flight_level);
          end
          default: rd.raw = dist_t'(clip16(flight_level - span
                                           + int'($urandom_range(0, 2 * span))));
        endcase
        rd.mark_unstable = ($urandom_range(0, 29) == 0);
      end
      readings_to_send.push_back(rd);
    end
  endtask

  // Driver: offers queued items, holds a stalled item, predicts on accept
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_reading(readings_to_send.pop_front());
      if (in_valid && in_stall) begin
        // stalled: payload and valid stay as they are
      end else if (readings_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        raw_distance_cm <= readings_to_send[0].raw;
        armed <= readings_to_send[0].armed;
        throttle_pwm <= readings_to_send[0].throttle;
        now_ms <= readings_to_send[0].now;
        mark_unstable <= readings_to_send[0].mark_unstable;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each accepted result, drives random and long stalls
  always @(posedge clk) begin : check_results
    distance_pair_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d/%0d with nothing expected",
                                    filtered_distance_cm, held_raw_cm));
        end else begin
          want = expected_results.pop_front();
          if (filtered_distance_cm !== want.filtered)
            report_mismatch($sformatf("filtered_distance_cm %0d, expected %0d",
                                      filtered_distance_cm, want.filtered));
          if (held_raw_cm !== want.held)
            report_mismatch($sformatf("held_raw_cm %0d, expected %0d",
                                      held_raw_cm, want.held));
        end
      end
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  // Stimulus sequence
  initial begin
    filter_config_t c;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    repeat (3) @(posedge clk);

    // filter off with the average bit set: output follows the held reading
    apply_config(build_config(2'd2, 16'd100, 16'd20, 16'd700, 8'd10, 16'd1100, 16'd0, 7'd3));
    @(negedge clk);
    push_reading(16'd0, 1'b0, 16'd0, 32'd0, 1'b0);
    push_reading(16'hFFFF, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    push_reading(16'd0, 1'b0, 16'd500, 32'd5, 1'b0);
    wait_drained();

    // filter and average on, default thresholds
    apply_config(build_config(2'd3, 16'd100, 16'd20, 16'd700, 8'd10, 16'd1100, 16'd0, 7'd3));
    @(negedge clk);
    push_reading(16'd0, 1'b1, 16'd0, 32'd0, 1'b0);      // armed, takeoff never seen
    push_reading(16'd50, 1'b0, 16'd0, 32'd10, 1'b0);    // ground, below glitch step
    push_reading(16'd500, 1'b0, 16'd0, 32'd20, 1'b0);   // ground clamp
    push_reading(16'd0, 1'b0, 16'd0, 32'd30, 1'b0);     // zero held
    push_reading(16'd60, 1'b1, 16'd1100, 32'd40, 1'b0); // throttle at threshold
    push_reading(16'd70, 1'b1, 16'd1101, 32'd1000, 1'b0); // takeoff
    push_reading(16'd400, 1'b1, 16'd1500, 32'd1000, 1'b0); // jump in hold window
    push_reading(16'd80, 1'b1, 16'd1500, 32'd1020, 1'b0);
    push_reading(16'd400, 1'b1, 16'd1500, 32'd1040, 1'b0); // upward jumps count
    push_reading(16'd400, 1'b1, 16'd1500, 32'd1060, 1'b0);
    push_reading(16'd400, 1'b1, 16'd1500, 32'd1080, 1'b0); // new level accepted
    push_reading(16'd200, 1'b1, 16'd1500, 32'd1100, 1'b0); // downward jump
    push_reading(16'd700, 1'b1, 16'd1500, 32'd1120, 1'b0);
    push_reading(16'd701, 1'b1, 16'd1500, 32'd1140, 1'b0); // above average range
    push_reading(16'd19, 1'b1, 16'd1500, 32'd1160, 1'b1);  // below average range
    push_reading(16'd0, 1'b1, 16'd1500, 32'd1180, 1'b0);
    push_reading(16'hFFFF, 1'b1, 16'hFFFF, 32'hFFFF_FFF0, 1'b0);
    push_reading(16'd120, 1'b1, 16'd1500, 32'h0000_0010, 1'b0); // time wraps
    push_reading(16'd1, 1'b0, 16'd0, 32'd20, 1'b1);
    wait_drained();

    clock_ms = $urandom;
    for (int p = 0; p < 14; p++) begin
      case (p)
        0:       c = build_config(2'd3, 16'd100, 16'd20, 16'd700, 8'd24, 16'd1100, 16'd500, 7'd3);
        1:       c = build_config(2'd3, 16'd0, 16'd20, 16'd700, 8'd0, 16'd1100, 16'd0, 7'd3);
        2:       c = build_config(2'd3, 16'hFFFF, 16'd0, 16'hFFFF, 8'd255, 16'd0,
                                  16'hFFFF, 7'd127);
        3:       c = build_config(2'd3, 16'd150, 16'd0, 16'hFFFF, 8'd1, 16'hFFFF, 16'd0, 7'd0);
        4:       c = build_config(2'd1, 16'd80, 16'd30, 16'd400, 8'd24, 16'd1000, 16'd200, 7'd2);
        default: c = random_config();
      endcase
      // idling: light sender / heavy receiver, then swapped, then none
      if (p == 5) begin
        send_idle_pct <= 84;
        recv_stall_pct <= 10;
      end else if (p == 10) begin
        send_idle_pct <= 0;
        recv_stall_pct <= 0;
      end
      apply_config(c);
      @(negedge clk);
      queue_flight(125);
      // long receiver hold while the sender keeps offering
      if (p == 2) hold_requests <= hold_requests + 1;
      wait_drained();
    end

    repeat (120) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
